// ===== design/hmac_pkg.sv =====
`default_nettype none
package hmac_pkg;

   localparam int unsigned WORD_W    = 32;
   localparam int unsigned CSR_COUNT = 8;
   localparam int unsigned ROUNDS    = 64;

   typedef logic [WORD_W-1:0] word_type;

   // register indexes
   typedef enum logic [2:0] {
      CSR_INNER_AB = 3'd0,
      CSR_INNER_CD = 3'd1,
      CSR_INNER_EF = 3'd2,
      CSR_INNER_GH = 3'd3,
      CSR_OUTER_AB = 3'd4,
      CSR_OUTER_CD = 3'd5,
      CSR_OUTER_EF = 3'd6,
      CSR_OUTER_GH = 3'd7
   } csr_index_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,     // waiting for a request word
      ST_PAD,      // writing padding into the block buffer
      ST_ROUND,    // one compression round per cycle
      ST_FOLD,     // add working vars into chaining state
      ST_OUTER,    // build the outer block from the inner digest
      ST_SEND      // four digest words out
   } state_type;

   // what follows after a compression finishes
   typedef enum logic [1:0] {
      NEXT_IDLE,   // block full mid-message, take more words
      NEXT_LEN,    // padding spilled, need a length-only block
      NEXT_OUTER,  // inner digest done, run outer hash
      NEXT_SEND    // outer digest done
   } next_type;

   localparam word_type PAD_WORD   = 32'h8000_0000;
   localparam word_type OUTER_BITS = 32'd768;
   localparam logic [60:0] KEY_BLOCK_BYTES = 61'd64;

   function automatic word_type round_k(input logic [5:0] idx);
      word_type k;
      unique case (idx)
         6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
         6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
         6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
         6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
         6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
         6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
         default: k = '0;
      endcase
      return k;
   endfunction

   function automatic word_type rotr(input word_type v, input int unsigned n);
      return (v >> n) | (v << (WORD_W - n));
   endfunction

endpackage
`default_nettype wire

// ===== design/hmac_sha256_prekeyed_core.sv =====
`default_nettype none
// HMAC-SHA-256 over a pre-keyed state. Load the inner and outer keyed chaining
// states (registers 0..3 and 4..7, earlier word in bits 63..32) while idle, then
// stream the message as big-endian 32-bit request words; byte_count applies only
// to the word marked last. The length in padding counts the 64-byte key block.
// A word that does not fill a block is stored straight into the block buffer; a
// word that completes a 16-word block holds req_ready low through the 64 rounds
// on the single round unit and then the fold. A last word is followed by padding
// writes, one or two inner compressions, an outer compression (its block built
// from the inner digest word by word) and then four digest words on rsp_*,
// index 0 first. req_ready stays low until the fourth digest word is taken, so
// no new request word is taken while a block is compressed or a digest is
// pending; the round unit does one SHA-256 round per cycle.
module hmac_sha256_prekeyed_core
   import hmac_pkg::*;
#(
   parameter int unsigned BLOCK_WORDS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [31:0] req_data_word,
   input  wire logic [2:0]  req_byte_count,
   input  wire logic        req_last,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [63:0]      rsp_digest_word,
   output logic [1:0]       rsp_word_index,
   output logic             rsp_digest_last,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_data
);

   localparam int unsigned BW = $clog2(BLOCK_WORDS);

   // config registers
   logic [63:0] csr_ff [CSR_COUNT];
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CSR_COUNT; i++) csr_ff[i] <= '0;
      end else if (csr_valid && csr_ready) begin
         csr_ff[csr_index] <= csr_data;
      end
   end
   assign csr_ready = 1'b1;

   state_type   state_ff, state_in;
   next_type    next_ff, next_in;
   word_type    buf_ff [BLOCK_WORDS];
   word_type    buf_in [BLOCK_WORDS];
   word_type    win_ff [16];
   word_type    win_in [16];
   word_type    v_ff [8];
   word_type    v_in [8];
   word_type    h_ff [8];
   word_type    h_in [8];
   logic [60:0] bytes_ff, bytes_in;
   logic [6:0]  rnd_ff, rnd_in;
   logic        busy_ff, busy_in;   // inside a message
   logic [BW:0] pad_ff, pad_in;     // padding write pointer
   logic [1:0]  oidx_ff, oidx_in;

   // one round of the shared unit
   word_type w_new, w_cur, t1, t2, s0, s1, ch, mj, g0, g1, wa, wb;
   always_comb begin
      wa = win_ff[4'(rnd_ff[3:0] + 4'd1)];
      wb = win_ff[4'(rnd_ff[3:0] + 4'd14)];
      g0 = rotr(wa, 7) ^ rotr(wa, 18) ^ (wa >> 3);
      g1 = rotr(wb, 17) ^ rotr(wb, 19) ^ (wb >> 10);
      w_new = win_ff[rnd_ff[3:0]] + g0 + win_ff[4'(rnd_ff[3:0] + 4'd9)] + g1;
      w_cur = (rnd_ff >= 7'd16) ? w_new : win_ff[rnd_ff[3:0]];
      s0 = rotr(v_ff[0], 2) ^ rotr(v_ff[0], 13) ^ rotr(v_ff[0], 22);
      mj = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      t2 = s0 + mj;
      s1 = rotr(v_ff[4], 6) ^ rotr(v_ff[4], 11) ^ rotr(v_ff[4], 25);
      ch = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      t1 = v_ff[7] + s1 + ch + round_k(rnd_ff[5:0]) + w_cur;
   end

   // last-word handling
   logic [2:0]   cnt;
   logic [BW-1:0] wi;
   word_type     keep, tail;
   logic [63:0]  bits;
   always_comb begin
      cnt  = (req_byte_count > 3'd4 || !req_last) ? 3'd4 : req_byte_count;
      wi   = bytes_ff[BW+1:2];
      keep = (cnt == 3'd0) ? '0 : ~(32'hFFFF_FFFF >> (6'd8 * 6'(cnt)));
      tail = (req_data_word & keep) | (PAD_WORD >> (6'd8 * 6'(cnt)));
      bits = {bytes_ff + KEY_BLOCK_BYTES, 3'b000};
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      next_in  = next_ff;
      buf_in   = buf_ff;
      win_in   = win_ff;
      v_in     = v_ff;
      h_in     = h_ff;
      bytes_in = bytes_ff;
      rnd_in   = rnd_ff;
      busy_in  = busy_ff;
      pad_in   = pad_ff;
      oidx_in  = oidx_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (!busy_ff) begin
                  for (int i = 0; i < 4; i++) begin
                     h_in[2*i]   = csr_ff[i][63:32];
                     h_in[2*i+1] = csr_ff[i][31:0];
                  end
                  bytes_in = '0;
               end
               busy_in = 1'b1;
               if (busy_ff) begin
                  bytes_in = bytes_ff + 61'(cnt);
               end else begin
                  bytes_in = 61'(cnt);
               end
               if (!req_last) begin
                  buf_in[busy_ff ? wi : '0] = req_data_word;
                  if (busy_ff && wi == BW'(BLOCK_WORDS - 1)) begin
                     next_in  = NEXT_IDLE;
                     state_in = ST_ROUND;
                     rnd_in   = '0;
                     win_in   = buf_in;
                     v_in     = busy_ff ? h_ff : h_in;
                  end
               end else begin
                  // pad pointer starts at the word holding 0x80: the tail, or the one after a full last word
                  buf_in[busy_ff ? wi : '0] = (cnt == 3'd4) ? req_data_word : tail;
                  pad_in   = (BW+1)'(busy_ff ? wi : '0);
                  if (cnt == 3'd4) pad_in = pad_in + 1'b1;
                  state_in = ST_PAD;
                  if (cnt == 3'd4 && pad_in != (BW+1)'(BLOCK_WORDS)) begin
                     buf_in[pad_in[BW-1:0]] = PAD_WORD;
                  end
               end
            end
         end
         ST_PAD: begin
            // pad_ff points at the word holding 0x80 (or BLOCK_WORDS if full)
            if (pad_ff == (BW+1)'(BLOCK_WORDS)) begin
               // full block before the pad word: compress, then a pad block
               state_in = ST_ROUND;
               rnd_in   = '0;
               win_in   = buf_ff;
               v_in     = h_ff;
               next_in  = NEXT_LEN;
               pad_in   = '0;
            end else if (pad_ff[BW-1:0] >= BW'(BLOCK_WORDS - 2)) begin
               for (int i = 0; i < BLOCK_WORDS; i++)
                  if (BW'(i) > pad_ff[BW-1:0]) buf_in[i] = '0;
               state_in = ST_ROUND;
               rnd_in   = '0;
               win_in   = buf_in;
               v_in     = h_ff;
               next_in  = NEXT_LEN;
               pad_in   = (BW+1)'(BLOCK_WORDS + 1);
            end else begin
               // clear remainder one word per cycle, then length
               if (pad_ff[BW-1:0] == BW'(BLOCK_WORDS - 3)) begin
                  buf_in[BLOCK_WORDS-2] = bits[63:32];
                  buf_in[BLOCK_WORDS-1] = bits[31:0];
                  state_in = ST_ROUND;
                  rnd_in   = '0;
                  win_in   = buf_in;
                  v_in     = h_ff;
                  next_in  = NEXT_OUTER;
               end else begin
                  buf_in[pad_ff[BW-1:0] + 1'b1] = '0;
                  pad_in = pad_ff + 1'b1;
               end
            end
         end
         ST_ROUND: begin
            if (rnd_ff >= 7'd16) win_in[rnd_ff[3:0]] = w_new;
            v_in[7] = v_ff[6]; v_in[6] = v_ff[5]; v_in[5] = v_ff[4];
            v_in[4] = v_ff[3] + t1;
            v_in[3] = v_ff[2]; v_in[2] = v_ff[1]; v_in[1] = v_ff[0];
            v_in[0] = t1 + t2;
            rnd_in  = rnd_ff + 1'b1;
            if (rnd_ff == 7'(ROUNDS - 1)) state_in = ST_FOLD;
         end
         ST_FOLD: begin
            for (int i = 0; i < 8; i++) h_in[i] = h_ff[i] + v_ff[i];
            rnd_in = '0;
            unique case (next_ff)
               NEXT_IDLE: state_in = ST_IDLE;
               NEXT_LEN: begin
                  // length-only block (rest already cleared or clear now)
                  for (int i = 0; i < BLOCK_WORDS - 2; i++) buf_in[i] = '0;
                  buf_in[BLOCK_WORDS-2] = bits[63:32];
                  buf_in[BLOCK_WORDS-1] = bits[31:0];
                  if (pad_ff == '0) buf_in[0] = PAD_WORD;
                  win_in   = buf_in;
                  v_in     = h_in;
                  state_in = ST_ROUND;
                  next_in  = NEXT_OUTER;
               end
               NEXT_OUTER: begin
                  pad_in   = '0;
                  state_in = ST_OUTER;
               end
               NEXT_SEND: begin
                  oidx_in  = '0;
                  state_in = ST_SEND;
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_OUTER: begin
            // move inner digest word by word, then start outer compression
            buf_in[pad_ff[2:0]] = h_ff[pad_ff[2:0]];
            pad_in = pad_ff + 1'b1;
            if (pad_ff[2:0] == 3'd7) begin
               for (int i = 8; i < BLOCK_WORDS; i++) buf_in[i] = '0;
               buf_in[8]  = PAD_WORD;
               buf_in[BLOCK_WORDS-1] = OUTER_BITS;
               win_in = buf_in;
               for (int i = 0; i < 4; i++) begin
                  h_in[2*i]   = csr_ff[4+i][63:32];
                  h_in[2*i+1] = csr_ff[4+i][31:0];
                  v_in[2*i]   = csr_ff[4+i][63:32];
                  v_in[2*i+1] = csr_ff[4+i][31:0];
               end
               rnd_in   = '0;
               state_in = ST_ROUND;
               next_in  = NEXT_SEND;
            end
         end
         ST_SEND: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               oidx_in = oidx_ff + 1'b1;
               if (oidx_ff == 2'd3) begin
                  state_in = ST_IDLE;
                  busy_in  = 1'b0;
                  bytes_in = '0;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_digest_word = {h_ff[{oidx_ff, 1'b0}], h_ff[{oidx_ff, 1'b1}]};
   assign rsp_word_index  = oidx_ff;
   assign rsp_digest_last = (oidx_ff == 2'd3);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         next_ff  <= NEXT_IDLE;
         bytes_ff <= '0;
         rnd_ff   <= '0;
         busy_ff  <= 1'b0;
         pad_ff   <= '0;
         oidx_ff  <= '0;
         for (int i = 0; i < 8; i++) begin
            v_ff[i] <= '0;
            h_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         next_ff  <= next_in;
         bytes_ff <= bytes_in;
         rnd_ff   <= rnd_in;
         busy_ff  <= busy_in;
         pad_ff   <= pad_in;
         oidx_ff  <= oidx_in;
         v_ff     <= v_in;
         h_ff     <= h_in;
      end
   end

   // block buffer and schedule window
   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
      win_ff <= win_in;
   end

endmodule
`default_nettype wire

// ===== verif/tb_hmac_sha256_prekeyed_core.sv =====
`default_nettype none

// expected digest word
typedef struct {
   logic [63:0] word;
   logic [1:0]  index;
   logic        last;
} digest_exp_t;

class hmac_scoreboard;
   logic [31:0] round_consts[64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   logic [63:0] keyed_regs[8];
   logic [31:0] msg_block[16];
   logic [31:0] chain[8];
   logic [60:0] msg_bytes;
   bit          in_message;
   digest_exp_t digest_q[$];
   int          errors;

   function new();
      foreach (keyed_regs[i]) keyed_regs[i] = '0;
      foreach (chain[i]) chain[i] = '0;
      foreach (msg_block[i]) msg_block[i] = '0;
      msg_bytes = '0;
      in_message = 0;
      errors = 0;
   endfunction

   task report(string msg);
      $display("MISMATCH %0t: %s", $realtime, msg);
      errors++;
   endtask

   function logic [31:0] ror(logic [31:0] v, int n);
      return (v >> n) | (v << (32 - n));
   endfunction

   function void load_chain(int base);
      for (int i = 0; i < 4; i++) begin
         chain[2*i]   = keyed_regs[base+i][63:32];
         chain[2*i+1] = keyed_regs[base+i][31:0];
      end
   endfunction

   // one SHA-256 block over msg_block into chain
   function void compress();
      logic [31:0] w[16];
      logic [31:0] v[8];
      logic [31:0] a, b, t1, t2, s0, s1, ch, mj;
      int slot;
      v = chain;
      w = msg_block;
      for (int r = 0; r < 64; r++) begin
         slot = r & 15;
         if (r >= 16) begin
            a = w[(r-15) & 15];
            b = w[(r-2) & 15];
            w[slot] = w[slot] + (ror(a, 7) ^ ror(a, 18) ^ (a >> 3)) + w[(r-7) & 15]
                      + (ror(b, 17) ^ ror(b, 19) ^ (b >> 10));
         end
         s0 = ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22);
         mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
         t2 = s0 + mj;
         s1 = ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25);
         ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
         t1 = v[7] + s1 + ch + round_consts[r] + w[slot];
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain[i] += v[i];
   endfunction

   // accepted request word
   function void note_request(logic [31:0] data, logic [2:0] cnt, logic lst);
      int wi;
      logic [31:0] keep;
      logic [63:0] bits;
      logic [31:0] inner[8];
      digest_exp_t e;
      if (!in_message) begin
         load_chain(0);
         msg_bytes = '0;
         in_message = 1;
      end
      if (cnt > 4 || !lst) cnt = 4;
      wi = msg_bytes[5:2];
      if (!lst) begin
         msg_block[wi] = data;
         msg_bytes += 4;
         if (wi == 15) compress();
         return;
      end
      // final word, padding, length with key block counted
      if (cnt == 4) begin
         msg_block[wi] = data;
         msg_bytes += 4;
         wi++;
         if (wi == 16) begin
            compress();
            wi = 0;
         end
         msg_block[wi] = 32'h8000_0000;
      end else begin
         keep = (cnt == 0) ? 32'h0 : (32'hffff_ffff << (32 - 8*cnt));
         msg_block[wi] = (data & keep) | (32'h80 << (24 - 8*cnt));
         msg_bytes += 61'(cnt);
      end
      for (int i = wi + 1; i < 16; i++) msg_block[i] = '0;
      if (wi >= 14) begin
         compress();
         foreach (msg_block[i]) msg_block[i] = '0;
      end
      bits = {msg_bytes + 61'd64, 3'b000};
      msg_block[14] = bits[63:32];
      msg_block[15] = bits[31:0];
      compress();
      // outer hash over inner digest
      inner = chain;
      load_chain(4);
      for (int i = 0; i < 8; i++) msg_block[i] = inner[i];
      msg_block[8] = 32'h8000_0000;
      for (int i = 9; i < 15; i++) msg_block[i] = '0;
      msg_block[15] = 32'd768;
      compress();
      for (int i = 0; i < 4; i++) begin
         e.word  = {chain[2*i], chain[2*i+1]};
         e.index = 2'(i);
         e.last  = (i == 3);
         digest_q.push_back(e);
      end
      in_message = 0;
   endfunction

   task check_result(logic [63:0] word, logic [1:0] index, logic lst);
      digest_exp_t e;
      if (digest_q.size() == 0) begin
         report($sformatf("unexpected digest word %h", word));
         return;
      end
      e = digest_q.pop_front();
      if (word !== e.word)
         report($sformatf("digest_word %h, expected %h", word, e.word));
      if (index !== e.index)
         report($sformatf("word_index %0d, expected %0d", index, e.index));
      if (lst !== e.last)
         report($sformatf("digest_last %b, expected %b", lst, e.last));
   endtask
endclass

module tb_hmac_sha256_prekeyed_core;
   import hmac_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [31:0] req_data_word = '0;
   logic [2:0]  req_byte_count = '0;
   logic        req_last = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [63:0] rsp_digest_word;
   logic [1:0]  rsp_word_index;
   logic        rsp_digest_last;
   logic        csr_valid = 0;
   logic        csr_ready;
   csr_index_type csr_index = CSR_INNER_AB;
   logic [63:0] csr_data = '0;

   hmac_scoreboard digests = new();
   int burst_left = 0;
   int items_sent = 0;
   int stall_mode = 0;
   int mode_cycles = 0;

   hmac_sha256_prekeyed_core dut (.*);

   always #2 clock = ~clock;

   initial begin
      #4ms;
      $display("tb_hmac_sha256_prekeyed_core: FAIL");
      $finish;
   end

   // result side: check and stall on a shifting pattern
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         digests.check_result(rsp_digest_word, rsp_word_index, rsp_digest_last);
      if (mode_cycles == 0) begin
         stall_mode  = $urandom_range(0, 2);
         mode_cycles = $urandom_range(20, 120);
      end
      mode_cycles--;
      case (stall_mode)
         0: begin
            rsp_ready <= 1'b1;
         end
         1: begin
            rsp_ready <= 1'($urandom_range(0, 1));
         end
         default: begin
            rsp_ready <= ($urandom_range(0, 3) == 0);
         end
      endcase
   end

   // one request word, bursts with random gaps
   task send_word(logic [31:0] data, logic [2:0] cnt, logic lst);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 10);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid      <= 1'b1;
      req_data_word  <= data;
      req_byte_count <= cnt;
      req_last       <= lst;
      do @(posedge clock); while (!req_ready);
      digests.note_request(data, cnt, lst);
      items_sent++;
   endtask

   // message of nwords; byte counts on inner words are arbitrary
   task send_message(int nwords, logic [2:0] final_cnt);
      for (int i = 0; i < nwords - 1; i++)
         send_word($urandom, 3'($urandom_range(0, 7)), 1'b0);
      send_word($urandom, final_cnt, 1'b1);
   endtask

   // caller drops csr_valid after the last write
   task write_reg(csr_index_type idx, logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      digests.keyed_regs[idx] = value;
   endtask

   // drain results and let the block settle before touching registers
   task wait_idle();
      req_valid <= 1'b0;
      burst_left = 0;
      while (digests.digest_q.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task load_keys(logic [63:0] v[8]);
      write_reg(CSR_INNER_AB, v[0]);
      write_reg(CSR_INNER_CD, v[1]);
      write_reg(CSR_INNER_EF, v[2]);
      write_reg(CSR_INNER_GH, v[3]);
      write_reg(CSR_OUTER_AB, v[4]);
      write_reg(CSR_OUTER_CD, v[5]);
      write_reg(CSR_OUTER_EF, v[6]);
      write_reg(CSR_OUTER_GH, v[7]);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [63:0] keys[8];
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset keys: empty message first
      send_word(32'h0, 3'd0, 1'b1);
      wait_idle();

      // standard initial values
      keys = '{64'h6a09e667_bb67ae85, 64'h3c6ef372_a54ff53a,
               64'h510e527f_9b05688c, 64'h1f83d9ab_5be0cd19,
               64'h6a09e667_bb67ae85, 64'h3c6ef372_a54ff53a,
               64'h510e527f_9b05688c, 64'h1f83d9ab_5be0cd19};
      load_keys(keys);
      send_word(32'hffff_ffff, 3'd1, 1'b1);
      send_word(32'hffff_ffff, 3'd3, 1'b1);
      send_word(32'hffff_ffff, 3'd4, 1'b1);
      send_word(32'h1234_5678, 3'd7, 1'b1);
      send_word(32'hdead_beef, 3'd5, 1'b1);
      // short count without last takes all four bytes
      send_word(32'hcafe_f00d, 3'd2, 1'b0);
      send_word(32'h0000_0000, 3'd2, 1'b1);
      send_word(32'h5555_aaaa, 3'd0, 1'b0);
      send_word(32'haaaa_5555, 3'd0, 1'b1);
      send_message(14, 3'd4);
      wait_idle();

      // all ones, then random key sets and finally all zeros
      foreach (keys[i]) keys[i] = '1;
      load_keys(keys);
      send_message(13, 3'd3);
      send_message(15, 3'd0);
      for (int ph = 0; ph < 4; ph++) begin
         wait_idle();
         foreach (keys[i]) keys[i] = {$urandom, $urandom};
         if (ph == 3) foreach (keys[i]) keys[i] = '0;
         load_keys(keys);
         while (items_sent < 100 * (ph + 1) + 5) begin
            if ($urandom_range(0, 9) == 0)
               send_message($urandom_range(28, 40), 3'($urandom_range(0, 7)));
            else
               send_message($urandom_range(1, 18), 3'($urandom_range(0, 7)));
         end
      end

      // drain and finish
      req_valid <= 1'b0;
      while (digests.digest_q.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (digests.errors == 0)
         $display("tb_hmac_sha256_prekeyed_core: PASS");
      else
         $display("tb_hmac_sha256_prekeyed_core: FAIL");
      $finish;
   end
endmodule

`default_nettype wire
